// File: sv/rps_pkg.sv
// Package for the ring protection switch controller.
// Holds the item, result and state types and the protocol codes.
// No dependencies.
package rps_pkg;

  localparam int AddrWidth  = 48;
  localparam int CountWidth = 16;

  localparam logic [1:0] REQ_TYPE_MSG   = 2'd0;
  localparam logic [1:0] REQ_TYPE_LOCAL = 2'd1;
  localparam logic [1:0] REQ_TYPE_TICK  = 2'd2;

  localparam logic [3:0] REQ_IDLE    = 4'd0;
  localparam logic [3:0] REQ_WAIT    = 4'd5;
  localparam logic [3:0] REQ_MANUAL  = 4'd6;
  localparam logic [3:0] REQ_DEGRADE = 4'd8;
  localparam logic [3:0] REQ_FAIL    = 4'd11;
  localparam logic [3:0] REQ_FORCED  = 4'd13;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_WRAPPED = 3'd2;

  localparam logic [1:0] CFG_STATION_ADDR  = 2'd0;
  localparam logic [1:0] CFG_IPS_ENABLE    = 2'd1;
  localparam logic [1:0] CFG_RESTORE_DELAY = 2'd2;

  localparam logic [CountWidth-1:0] RestoreDelayReset = 16'd10;
  localparam logic [CountWidth-1:0] CountMax          = 16'hFFFF;

  typedef struct packed {
    logic [1:0]           req_type;
    logic                 ring;
    logic [3:0]           request_code;
    logic [2:0]           path_status;
    logic                 long_path;
    logic [AddrWidth-1:0] originator;
  } item_t;

  typedef struct packed {
    logic       packet_valid;
    logic       tx_ring;
    logic [3:0] tx_request;
    logic [2:0] tx_status;
    logic       tx_long_path;
    logic       wrap_enabled;
    logic       ips_state;
    logic       neighbor_mismatch;
    logic       last;
  } result_t;

  typedef struct packed {
    logic                       wrapped;
    logic [1:0]                 nbr_valid;
    logic [1:0]                 waiting;
    logic [1:0][CountWidth-1:0] elapsed;
  } ips_ctrl_t;

  function automatic logic is_switch_request(input logic [3:0] code);
    return (code == REQ_MANUAL) || (code == REQ_DEGRADE) ||
           (code == REQ_FAIL) || (code == REQ_FORCED);
  endfunction

endpackage

// File: sv/rps_step.sv
// Combinational step of the protection switch: next state and results for one item.
// Depends on rps_pkg.
module rps_step (
  input  rps_pkg::item_t                      item,
  input  rps_pkg::ips_ctrl_t                  ctrl,
  input  logic [rps_pkg::AddrWidth-1:0]       nbr_addr,
  input  logic [rps_pkg::AddrWidth-1:0]       station_addr,
  input  logic                                ips_enable,
  input  logic [rps_pkg::CountWidth-1:0]      restore_delay_ticks,
  output rps_pkg::ips_ctrl_t                  ctrl_next,
  output logic                                nbr_write,
  output rps_pkg::result_t                    res0,
  output rps_pkg::result_t                    res1,
  output logic                                two
);
  import rps_pkg::*;

  logic mism;
  logic [1:0][CountWidth-1:0] elapsed_tick;

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      elapsed_tick[r] = (ctrl.waiting[r] && ctrl.elapsed[r] != CountMax) ?
                        ctrl.elapsed[r] + CountWidth'(1) : ctrl.elapsed[r];
    end
  end

  always_comb begin
    ctrl_next = ctrl;
    nbr_write = 1'b0;
    mism      = 1'b0;
    two       = 1'b0;
    res0      = '0;
    res1      = '0;
    case (item.req_type)
      REQ_TYPE_MSG: begin
        if (item.originator != station_addr) begin
          if (!item.long_path) begin
            mism = ctrl.nbr_valid[item.ring] && (nbr_addr != item.originator);
            ctrl_next.nbr_valid[item.ring] = 1'b1;
            nbr_write = 1'b1;
          end
          if (!ctrl.wrapped) begin
            if (is_switch_request(item.request_code) && !item.long_path &&
                item.path_status == ST_WRAPPED) begin
              ctrl_next.wrapped  = 1'b1;
              two                = 1'b1;
              res0.packet_valid  = 1'b1;
              res0.tx_ring       = item.ring;
              res0.tx_request    = REQ_IDLE;
              res0.tx_status     = ST_WRAPPED;
              res0.tx_long_path  = 1'b0;
              res1.packet_valid  = 1'b1;
              res1.tx_ring       = ~item.ring;
              res1.tx_request    = item.request_code;
              res1.tx_status     = ST_WRAPPED;
              res1.tx_long_path  = 1'b1;
            end
          end else if (!item.long_path && item.request_code == REQ_IDLE &&
                       item.path_status == ST_IDLE) begin
            ctrl_next.wrapped = 1'b0;
          end
        end
      end
      REQ_TYPE_LOCAL: begin
        if (item.request_code == REQ_WAIT) begin
          if (ctrl.wrapped && !ctrl.waiting[item.ring]) begin
            ctrl_next.waiting[item.ring] = 1'b1;
            ctrl_next.elapsed[item.ring] = '0;
          end
        end else begin
          ctrl_next.waiting[item.ring] = 1'b0;
          ctrl_next.elapsed[item.ring] = '0;
        end
      end
      REQ_TYPE_TICK: begin
        ctrl_next.elapsed = elapsed_tick;
        if (ips_enable) begin
          if (ctrl.wrapped && ctrl.waiting[0] && ctrl.waiting[1] &&
              elapsed_tick[0] >= restore_delay_ticks &&
              elapsed_tick[1] >= restore_delay_ticks) begin
            ctrl_next.wrapped = 1'b0;
            ctrl_next.waiting = '0;
            ctrl_next.elapsed = '0;
          end
          if (!ctrl_next.wrapped) begin
            two               = 1'b1;
            res0.packet_valid = 1'b1;
            res0.tx_ring      = 1'b0;
            res0.tx_request   = REQ_IDLE;
            res0.tx_status    = ST_IDLE;
            res1.packet_valid = 1'b1;
            res1.tx_ring      = 1'b1;
            res1.tx_request   = REQ_IDLE;
            res1.tx_status    = ST_IDLE;
          end
        end
      end
      default: begin
      end
    endcase
    res0.wrap_enabled      = ctrl_next.wrapped;
    res0.ips_state         = ctrl_next.wrapped;
    res0.neighbor_mismatch = mism;
    res0.last              = ~two;
    res1.wrap_enabled      = ctrl_next.wrapped;
    res1.ips_state         = ctrl_next.wrapped;
    res1.neighbor_mismatch = mism;
    res1.last              = 1'b1;
  end

endmodule

// File: sv/rps_out_buf.sv
// Result buffer holding the one or two results of an item and presenting them in order.
// Depends on rps_pkg.
module rps_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  rps_pkg::result_t   res0,
  input  rps_pkg::result_t   res1,
  input  logic               two,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_ready,
  output rps_pkg::result_t   head
);
  import rps_pkg::*;

  logic [1:0] count;
  result_t    tail;
  logic       out_fire;

  assign out_valid = (count != 2'd0);
  assign out_fire  = out_valid && out_ready;
  assign can_load  = (count == 2'd0) || (count == 2'd1 && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= two ? 2'd2 : 2'd1;
    end else if (out_fire) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      head <= res0;
      tail <= res1;
    end else if (out_fire) begin
      head <= tail;
    end
  end

endmodule

// File: sv/ring_protection_switch_fsm.sv
// Top level of the ring protection switch controller.
// Depends on rps_pkg, rps_step and rps_out_buf.
//
// Input beats carry a received protection message, a local request or a tick.
// Each input beat yields one or two result beats on the output channel, the
// final one marked by last. Configuration writes on the cfg channel are
// always accepted, cfg_ready being tied high; they should be made only
// while the block is idle. An accepted beat is held in the input register
// until the result buffer can load; the step logic then writes its results
// into the result buffer, from which the first result is offered.
// The result buffer delivers one result per cycle while the receiver is
// ready, so the two results of an item follow back to back.
// When the receiver stalls, the buffer holds its results, the input register
// holds one further beat and in_ready then falls until space is freed.
// Reset clears the wrap state, learned-neighbour valid flags, restore flags
// and counters, and restores the registers to their defaults (own address 0,
// protection disabled, restore delay of ten ticks).
module ring_protection_switch_fsm (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     req_type,
  input  logic                           ring,
  input  logic [3:0]                     request_code,
  input  logic [2:0]                     path_status,
  input  logic                           long_path,
  input  logic [rps_pkg::AddrWidth-1:0]  originator,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           packet_valid,
  output logic                           tx_ring,
  output logic [3:0]                     tx_request,
  output logic [2:0]                     tx_status,
  output logic                           tx_long_path,
  output logic                           wrap_enabled,
  output logic                           ips_state,
  output logic                           neighbor_mismatch,
  output logic                           last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [rps_pkg::AddrWidth-1:0]  cfg_data
);
  import rps_pkg::*;

  logic [AddrWidth-1:0]   station_addr;
  logic                   ips_enable;
  logic [CountWidth-1:0]  restore_delay_ticks;
  logic                   in_full;
  item_t                  item;
  ips_ctrl_t              ctrl;
  ips_ctrl_t              ctrl_next;
  logic [1:0][AddrWidth-1:0] nbr_address;
  logic                   nbr_write;
  result_t                res0;
  result_t                res1;
  result_t                head;
  logic                   two;
  logic                   can_load;
  logic                   step_fire;
  logic                   in_fire;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign step_fire = in_full && can_load;
  assign in_ready  = !in_full || step_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      station_addr        <= '0;
      ips_enable          <= 1'b0;
      restore_delay_ticks <= RestoreDelayReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STATION_ADDR:  station_addr        <= cfg_data;
        CFG_IPS_ENABLE:    ips_enable          <= cfg_data[0];
        CFG_RESTORE_DELAY: restore_delay_ticks <= cfg_data[CountWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= in_fire || (in_full && !step_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item <= '{req_type, ring, request_code, path_status, long_path, originator};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else if (step_fire) begin
      ctrl <= ctrl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire && nbr_write) begin
      nbr_address[item.ring] <= item.originator;
    end
  end

  rps_step u_step (
    .item                (item),
    .ctrl                (ctrl),
    .nbr_addr            (nbr_address[item.ring]),
    .station_addr        (station_addr),
    .ips_enable          (ips_enable),
    .restore_delay_ticks (restore_delay_ticks),
    .ctrl_next           (ctrl_next),
    .nbr_write           (nbr_write),
    .res0                (res0),
    .res1                (res1),
    .two                 (two)
  );

  rps_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (step_fire),
    .res0      (res0),
    .res1      (res1),
    .two       (two),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign packet_valid      = head.packet_valid;
  assign tx_ring           = head.tx_ring;
  assign tx_request        = head.tx_request;
  assign tx_status         = head.tx_status;
  assign tx_long_path      = head.tx_long_path;
  assign wrap_enabled      = head.wrap_enabled;
  assign ips_state         = head.ips_state;
  assign neighbor_mismatch = head.neighbor_mismatch;
  assign last              = head.last;

endmodule
